### rtl/qdec_pkg.sv
// Package for the quadrature decoder: item codes, command ops, result record,
// transition table and fixed constants. No dependencies.
package qdec_pkg;

	localparam int DEF_TIME_BITS       = 48;
	localparam int DEF_SPEED_FRAC_BITS = 8;
	localparam int QUEUE_DEPTH         = 2;
	localparam int QUOT_W              = 32;
	localparam int CFG_IDX_W           = 1;
	localparam int CFG_DATA_W          = 24;
	localparam int PORT_TIME_W         = 48;

	localparam logic [15:0] CPR_RESET     = 16'd4096;
	localparam logic [23:0] WINDOW_RESET  = 24'd100000;
	localparam logic [25:0] US_PER_MINUTE = 26'd60000000;
	localparam logic [30:0] PULSE_MAX     = 31'h7FFF_FFFF;
	localparam logic [31:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SPEED_NEG_MAX = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNTS_PER_REV = 1'b0,
		REG_SPEED_WINDOW   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_INDEX  = 2'd1,
		KIND_SPEED  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_UP    = 3'd1,
		OP_DOWN  = 3'd2,
		OP_INDEX = 3'd3,
		OP_SPEED = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	localparam int OP_W = $bits(op_t);

	// x4 transition table indexed by {prev_ab, cur_ab}: +1 cw, -1 ccw, 0 none
	localparam logic signed [1:0] STEP_TABLE [16] = '{
		2'sd0,  -2'sd1, 2'sd1,  2'sd0,
		2'sd1,  2'sd0,  2'sd0,  -2'sd1,
		-2'sd1, 2'sd0,  2'sd0,  2'sd1,
		2'sd0,  2'sd1,  -2'sd1, 2'sd0
	};

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] revolutions;
		logic [30:0]        pulses_in_rev;
		logic               clockwise;
		logic signed [31:0] speed_rpm_q8;
		logic               speed_updated;
		logic [47:0]        index_time;
	} res_t;

endpackage

### rtl/qdec_fifo.sv
// Small first-in first-out queue with full/empty flags.
// Uses qdec_pkg only for its default depth.
module qdec_fifo import qdec_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/qdec_front.sv
// Front end: accepts items, tracks the previous A/B state and classifies each
// item into a command op for the back end. Depends on qdec_pkg.
module qdec_front import qdec_pkg::*; #(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   q_full,
	input  logic [1:0]             kind,
	input  logic                   a_level,
	input  logic                   b_level,
	input  logic [PORT_TIME_W-1:0] time_us,
	output logic                   cmd_push,
	output op_t                    cmd_op,
	output logic [TIME_BITS-1:0]   cmd_time
);

	logic [1:0]        prev_ab_q;
	logic              primed_q;
	logic [1:0]        cur_ab;
	logic signed [1:0] step;
	kind_t             kind_c;

	assign kind_c   = kind_t'(kind);
	assign cur_ab   = {a_level, b_level};
	assign step     = STEP_TABLE[{prev_ab_q, cur_ab}];
	assign cmd_push = push && !q_full;
	assign cmd_time = TIME_BITS'(time_us);

	always_comb begin
		case (kind_c)
			KIND_SAMPLE: begin
				if (!primed_q || step == 2'sd0) begin
					cmd_op = OP_HOLD;
				end else if (step > 2'sd0) begin
					cmd_op = OP_UP;
				end else begin
					cmd_op = OP_DOWN;
				end
			end
			KIND_INDEX: cmd_op = OP_INDEX;
			KIND_SPEED: cmd_op = OP_SPEED;
			default:    cmd_op = OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= 2'b00;
			primed_q  <= 1'b0;
		end else if (cmd_push && kind_c == KIND_SAMPLE) begin
			prev_ab_q <= cur_ab;
			primed_q  <= 1'b1;
		end
	end

endmodule

### rtl/qdec_div.sv
// Restoring divider, one quotient bit per cycle, QUOT_W bits.
// Quotient bit QUOT_W-1 set means the true quotient overflows. Depends on qdec_pkg.
module qdec_div import qdec_pkg::*; #(
	parameter int NUM_W = 66,
	parameter int DEN_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	localparam int DIV_W = (NUM_W > DEN_W + QUOT_W - 1) ? NUM_W : DEN_W + QUOT_W - 1;
	localparam int CW    = $clog2(QUOT_W + 1);

	logic [NUM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge   = (DIV_W'(rem_q) >= dsh_q);
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num;
				dsh_q  <= DIV_W'(den) << (QUOT_W - 1);
				quot_q <= '0;
				cnt_q  <= CW'(QUOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - NUM_W'(dsh_q);
				end
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/qdec_back.sv
// Back end: executes commands on the counter state, runs the speed sequence
// (multiplies, then qdec_div) and pushes one result per command. Depends on qdec_pkg.
module qdec_back import qdec_pkg::*; #(
	parameter int TIME_BITS       = DEF_TIME_BITS,
	parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  op_t                  cmd_op,
	input  logic [TIME_BITS-1:0] cmd_time,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output res_t                 res_data,
	input  logic [15:0]          cpr,
	input  logic [23:0]          win
);

	localparam int BASE_W = 58;
	localparam int NUM_W  = BASE_W + SPEED_FRAC_BITS;
	localparam int DEN_W  = TIME_BITS + 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_BASE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV
	} state_t;

	state_t st_q, st_d;

	logic signed [31:0]   pos_q, pos_d;
	logic signed [31:0]   rev_q, rev_d;
	logic [30:0]          pulses_q, pulses_d;
	logic                 dir_q, dir_d;
	logic [TIME_BITS-1:0] idx_time_q, idx_time_d;
	logic [TIME_BITS-1:0] spd_time_q, spd_time_d;
	logic [31:0]          spd_cnt_q, spd_cnt_d;
	logic [31:0]          speed_q, speed_d;
	logic                 neg_q, neg_d;
	logic [31:0]          mag_q, mag_d;
	logic [TIME_BITS-1:0] dt_q, dt_d;
	logic [BASE_W-1:0]    base_q, base_d;
	logic [DEN_W-1:0]     den_q, den_d;
	logic                 div_start_q, div_start_d;

	logic [TIME_BITS-1:0] dt;
	logic [31:0]          dc;
	logic [15:0]          cpr_eff;
	logic [23:0]          win_eff;
	logic [63:0]          dt64;
	logic [47:0]          p_lo;
	logic [47:0]          p_hi;
	logic [BASE_W-1:0]    base_p;
	logic                 updated;
	logic                 div_done;
	logic [QUOT_W-1:0]    div_quot;
	logic [31:0]          sval;

	assign cpr_eff = (cpr == 16'd0) ? 16'd1 : cpr;
	assign win_eff = (win == 24'd0) ? 24'd1 : win;
	assign dt      = cmd_time - spd_time_q;
	assign dc      = pos_q - spd_cnt_q;
	assign dt64    = 64'(dt_q);
	assign p_lo    = 48'(dt64[31:0]) * 48'(cpr_eff);
	assign p_hi    = 48'(dt64[63:32]) * 48'(cpr_eff);
	assign base_p  = BASE_W'(mag_q) * BASE_W'(US_PER_MINUTE);

	qdec_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (NUM_W'(base_q) << SPEED_FRAC_BITS),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// signed, saturated speed; a positive value flips when turning ccw
	always_comb begin
		if (neg_q) begin
			sval = div_quot[QUOT_W-1] ? SPEED_NEG_MAX : 32'(-div_quot);
		end else begin
			sval = div_quot[QUOT_W-1] ? SPEED_POS_MAX : div_quot;
		end
		if (!dir_q && sval != 32'd0 && !sval[31]) begin
			sval = -sval;
		end
	end

	always_comb begin
		st_d        = st_q;
		pos_d       = pos_q;
		rev_d       = rev_q;
		pulses_d    = pulses_q;
		dir_d       = dir_q;
		idx_time_d  = idx_time_q;
		spd_time_d  = spd_time_q;
		spd_cnt_d   = spd_cnt_q;
		speed_d     = speed_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		dt_d        = dt_q;
		base_d      = base_q;
		den_d       = den_q;
		div_start_d = 1'b0;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		updated     = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd_op)
						OP_UP: begin
							pos_d    = pos_q + 32'sd1;
							dir_d    = 1'b1;
							if (pulses_q != PULSE_MAX) pulses_d = pulses_q + 31'd1;
							res_push = 1'b1;
						end
						OP_DOWN: begin
							pos_d    = pos_q - 32'sd1;
							dir_d    = 1'b0;
							if (pulses_q != PULSE_MAX) pulses_d = pulses_q + 31'd1;
							res_push = 1'b1;
						end
						OP_INDEX: begin
							pulses_d   = '0;
							rev_d      = dir_q ? rev_q + 32'sd1 : rev_q - 32'sd1;
							idx_time_d = cmd_time;
							res_push   = 1'b1;
						end
						OP_SPEED: begin
							if (dt >= TIME_BITS'(win_eff)) begin
								neg_d      = dc[31];
								mag_d      = dc[31] ? -dc : dc;
								dt_d       = dt;
								spd_cnt_d  = pos_q;
								spd_time_d = cmd_time;
								st_d       = ST_MUL_BASE;
							end else begin
								res_push = 1'b1;
							end
						end
						OP_CLEAR: begin
							pos_d     = '0;
							rev_d     = '0;
							pulses_d  = '0;
							spd_cnt_d = '0;
							speed_d   = '0;
							res_push  = 1'b1;
						end
						default: res_push = 1'b1;
					endcase
				end
			end
			ST_MUL_BASE: begin
				base_d = base_p;
				st_d   = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				den_d = DEN_W'(p_lo);
				st_d  = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				den_d       = DEN_W'({p_hi, 32'd0} + 80'(den_q));
				div_start_d = 1'b1;
				st_d        = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					speed_d  = sval;
					updated  = 1'b1;
					res_push = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		res_data.position      = pos_d;
		res_data.revolutions   = rev_d;
		res_data.pulses_in_rev = pulses_d;
		res_data.clockwise     = dir_d;
		res_data.speed_rpm_q8  = speed_d;
		res_data.speed_updated = updated;
		res_data.index_time    = PORT_TIME_W'(idx_time_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pos_q       <= '0;
			rev_q       <= '0;
			pulses_q    <= '0;
			dir_q       <= 1'b1;
			idx_time_q  <= '0;
			spd_time_q  <= '0;
			spd_cnt_q   <= '0;
			speed_q     <= '0;
			div_start_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			pos_q       <= pos_d;
			rev_q       <= rev_d;
			pulses_q    <= pulses_d;
			dir_q       <= dir_d;
			idx_time_q  <= idx_time_d;
			spd_time_q  <= spd_time_d;
			spd_cnt_q   <= spd_cnt_d;
			speed_q     <= speed_d;
			div_start_q <= div_start_d;
		end
	end

	always_ff @(posedge clk) begin
		neg_q  <= neg_d;
		mag_q  <= mag_d;
		dt_q   <= dt_d;
		base_q <= base_d;
		den_q  <= den_d;
	end

endmodule

### rtl/quadrature_decoder_with_index_speed.sv
// x4 quadrature decoder with index and speed: top level.
// Uses qdec_pkg, qdec_fifo, qdec_front and qdec_back.
//
// Input channel: push/full. An item (kind, a_level, b_level, time_us) transfers
// on a clock edge with push high and full low. Kinds: A/B sample, index edge,
// speed request, clear.
// Result channel: empty/pop. Every item gives exactly one result; the oldest
// result sits on the result ports while empty is low and transfers on an edge
// with pop high.
// Configuration: cfg_we/cfg_index/cfg_wdata writes counts_per_rev (index 0)
// or speed_window_us (index 1); write only while idle.
// Timing: samples, index edges, clears and speed requests whose window has not
// elapsed pass through the command queue and the result queue; a speed
// recalculation runs three multiply steps, a divider load, the bit-per-cycle
// divider and a result write. Throughput is one item per cycle for the former
// while the result queue has room; a recalculation holds the back end meanwhile.
// A two-entry command queue and a two-entry result queue decouple the sides:
// the input keeps accepting while a result waits, until the command queue fills.
// Reset (asynchronous, active low) empties both queues, clears all counters,
// sets the direction to clockwise and loads the register defaults.
module quadrature_decoder_with_index_speed import qdec_pkg::*; #(
	parameter int TIME_BITS       = DEF_TIME_BITS,
	parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [1:0]             kind,
	input  logic                   a_level,
	input  logic                   b_level,
	input  logic [PORT_TIME_W-1:0] time_us,
	output logic                   empty,
	input  logic                   pop,
	output logic signed [31:0]     position,
	output logic signed [31:0]     revolutions,
	output logic [30:0]            pulses_in_rev,
	output logic                   clockwise,
	output logic signed [31:0]     speed_rpm_q8,
	output logic                   speed_updated,
	output logic [PORT_TIME_W-1:0] index_time,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int CMD_W = OP_W + TIME_BITS;

	logic [15:0]          cpr_q;
	logic [23:0]          win_q;
	logic                 cmd_push;
	op_t                  front_op;
	logic [TIME_BITS-1:0] front_time;
	logic [CMD_W-1:0]     cmd_rd;
	logic                 cmd_empty;
	logic                 cmd_pop;
	logic                 res_push;
	logic                 res_full;
	res_t                 res_wr;
	res_t                 res_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= CPR_RESET;
			win_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COUNTS_PER_REV: cpr_q <= cfg_wdata[15:0];
				REG_SPEED_WINDOW:   win_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	qdec_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_full   (full),
		.kind     (kind),
		.a_level  (a_level),
		.b_level  (b_level),
		.time_us  (time_us),
		.cmd_push (cmd_push),
		.cmd_op   (front_op),
		.cmd_time (front_time)
	);

	qdec_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data ({front_op, front_time}),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.full    (full),
		.empty   (cmd_empty)
	);

	qdec_back #(
		.TIME_BITS       (TIME_BITS),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd_op    (op_t'(cmd_rd[TIME_BITS +: OP_W])),
		.cmd_time  (cmd_rd[TIME_BITS-1:0]),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wr),
		.cpr       (cpr_q),
		.win       (win_q)
	);

	qdec_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.rd_en   (pop),
		.rd_data (res_rd),
		.full    (res_full),
		.empty   (empty)
	);

	assign position      = res_rd.position;
	assign revolutions   = res_rd.revolutions;
	assign pulses_in_rev = res_rd.pulses_in_rev;
	assign clockwise     = res_rd.clockwise;
	assign speed_rpm_q8  = res_rd.speed_rpm_q8;
	assign speed_updated = res_rd.speed_updated;
	assign index_time    = res_rd.index_time;

endmodule

### rtl/qdec_chk.sv
// Port-level checks for the quadrature decoder top, attached with bind.
// Depends on quadrature_decoder_with_index_speed port names.
module qdec_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] position,
	input logic signed [31:0] speed_rpm_q8,
	input logic [47:0]        index_time
);

	a_reset_queues: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not empty during reset");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("input queue filled without a transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(position) && $stable(speed_rpm_q8)
			&& $stable(index_time)))
		else $error("waiting result changed or vanished");

endmodule

bind quadrature_decoder_with_index_speed qdec_chk u_chk (.*);
